FILE: design/ssdc_pkg.sv
// ----------------------------------------------------------------------------
// ssdc_pkg: shared types and constants
// Gain table, stage codes and control word for the spring-damper centering
// block.
// ----------------------------------------------------------------------------
package ssdc_pkg;

  localparam int POS_W   = 18;
  localparam int VEL_W   = 23;
  localparam int FORCE_W = 31;
  localparam int K_W     = 11;
  localparam int GAIN_W  = 4;
  localparam int TICK_W  = 15;
  localparam int CNT_W   = 16;
  localparam int CFG_W   = 18;

  typedef logic [K_W-1:0] k_t;

  typedef enum logic [1:0] {
    STAGE_INIT = 2'd0,
    STAGE_MID  = 2'd1,
    STAGE_TOP  = 2'd2
  } stage_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef enum logic [2:0] {
    REG_AXIS_MODE   = 3'd0,
    REG_CENTER_X    = 3'd1,
    REG_CENTER_Y    = 3'd2,
    REG_CENTER_Z    = 3'd3,
    REG_DAMPING     = 3'd4,
    REG_STAGE_ONE   = 3'd5,
    REG_STAGE_TWO   = 3'd6,
    REG_RECENTER    = 3'd7
  } reg_idx_t;

  localparam k_t K_SOFT_XY = 11'd100;
  localparam k_t K_SOFT_Z  = 11'd500;
  localparam k_t K_MID     = 11'd1000;
  localparam k_t K_TOP     = 11'd2000;

  // per-tick control word, decoded from the counters at accept time
  typedef struct packed {
    stage_t     stage;
    logic [2:0] active;   // bit 0 x, bit 1 y, bit 2 z
    logic       pending;
  } ctl_t;

  function automatic k_t k_sel(stage_t stage, axis_t axis);
    k_t k;
    case (stage)
      STAGE_TOP: k = K_TOP;
      STAGE_MID: k = K_MID;
      default:   k = (axis == AXIS_Z) ? K_SOFT_Z : K_SOFT_XY;
    endcase
    return k;
  endfunction

endpackage

FILE: design/staged_spring_damper_centering.sv
// ----------------------------------------------------------------------------
// staged_spring_damper_centering: three-axis PD centering controller
// Input words pass the stage A product registers, then the output register; one word
// per cycle unless out_tready stalls. Throughput is set by the two-stage lane pipeline
// (multiply, then sum and saturate); the output register lets a new word enter while a
// result waits. Reset (synchronous, rst_n low) clears counters and valids and loads the
// register defaults.
// ----------------------------------------------------------------------------
module staged_spring_damper_centering (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, button_pressed, zero pad
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // force_x, force_y, force_z, recenter_pending, gain_stage
  output logic [95:0]  out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [17:0]  cfg_data
);
  import ssdc_pkg::*;

  logic                    a_v_r, a_v_nxt;
  logic                    out_v_r, out_v_nxt;
  logic                    adv_a, adv_b, accept, en_b;
  ctl_t                    ctl, ctl_a_r, ctl_o_r;
  logic signed [POS_W-1:0] cx, cy, cz;
  logic [GAIN_W-1:0]       gain;
  logic signed [FORCE_W-1:0] fx, fy, fz;

  assign adv_b     = !out_v_r || out_tready;
  assign adv_a     = !a_v_r || adv_b;
  assign in_tready = adv_a;
  assign accept    = in_tvalid && in_tready;
  assign en_b      = adv_b && a_v_r;
  assign cfg_ready = 1'b1;

  ssdc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_idx  (reg_idx_t'(cfg_index)),
    .cfg_val  (cfg_data),
    .step     (accept),
    .button   (in_tdata[123]),
    .ctl      (ctl),
    .center_x (cx),
    .center_y (cy),
    .center_z (cz),
    .gain     (gain)
  );

  ssdc_lane u_lane_x (
    .clk     (clk),
    .en_a    (accept),
    .en_b    (en_b),
    .k       (k_sel(ctl.stage, AXIS_X)),
    .active  (ctl.active[0]),
    .pos     (in_tdata[17:0]),
    .center  (cx),
    .vel     (in_tdata[76:54]),
    .gain    (gain),
    .force_o (fx)
  );

  ssdc_lane u_lane_y (
    .clk     (clk),
    .en_a    (accept),
    .en_b    (en_b),
    .k       (k_sel(ctl.stage, AXIS_Y)),
    .active  (ctl.active[1]),
    .pos     (in_tdata[35:18]),
    .center  (cy),
    .vel     (in_tdata[99:77]),
    .gain    (gain),
    .force_o (fy)
  );

  ssdc_lane u_lane_z (
    .clk     (clk),
    .en_a    (accept),
    .en_b    (en_b),
    .k       (k_sel(ctl.stage, AXIS_Z)),
    .active  (ctl.active[2]),
    .pos     (in_tdata[53:36]),
    .center  (cz),
    .vel     (in_tdata[122:100]),
    .gain    (gain),
    .force_o (fz)
  );

  always_comb begin
    a_v_nxt   = adv_a ? accept : a_v_r;
    out_v_nxt = adv_b ? a_v_r : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      a_v_r   <= a_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // status rides alongside the lane pipeline
  always_ff @(posedge clk) begin
    if (accept) begin
      ctl_a_r <= ctl;
    end
    if (en_b) begin
      ctl_o_r <= ctl_a_r;
    end
  end

  // merge: lane forces and status form the output word
  assign out_tvalid = out_v_r;
  assign out_tdata  = {ctl_o_r.stage, ctl_o_r.pending, fz, fy, fx};

`ifndef SYNTH
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    a_v_r && !adv_b |=> a_v_r)
    else $error("stage A word dropped while output stalled");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> a_v_r)
    else $error("accepted word did not reach stage A");

  a_stage_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[95:94] == STAGE_INIT || out_tdata[95:94] == STAGE_MID ||
                    out_tdata[95:94] == STAGE_TOP))
    else $error("gain stage code out of range");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !a_v_r |-> in_tready)
    else $error("input stalled with empty pipeline");
`endif

endmodule

FILE: design/ssdc_lane.sv
// ----------------------------------------------------------------------------
// ssdc_lane: one axis of the spring-damper law
// Stage A forms the spring and damper products, stage B sums, saturates and
// blanks a free axis.
// ----------------------------------------------------------------------------
module ssdc_lane (
  input  logic                                clk,
  input  logic                                en_a,
  input  logic                                en_b,
  input  ssdc_pkg::k_t                        k,
  input  logic                                active,
  input  logic signed [ssdc_pkg::POS_W-1:0]   pos,
  input  logic signed [ssdc_pkg::POS_W-1:0]   center,
  input  logic signed [ssdc_pkg::VEL_W-1:0]   vel,
  input  logic        [ssdc_pkg::GAIN_W-1:0]  gain,
  output logic signed [ssdc_pkg::FORCE_W-1:0] force_o
);
  import ssdc_pkg::*;

  localparam int DIFF_W = POS_W + 1;
  localparam int PK_W   = DIFF_W + K_W + 1;
  localparam int PC_W   = VEL_W + GAIN_W + 1;
  localparam int SUM_W  = PK_W + 2;
  localparam logic signed [SUM_W-1:0] LIMIT = SUM_W'(1000000000);

  logic signed [DIFF_W-1:0] diff;
  logic signed [PK_W-1:0]   pk_r, pk_nxt;
  logic signed [PC_W-1:0]   pc_r, pc_nxt;
  logic                     act_r;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  sat;
  logic signed [FORCE_W-1:0] force_r, force_nxt;

  assign diff   = DIFF_W'(pos) - DIFF_W'(center);
  assign pk_nxt = $signed({1'b0, k}) * diff;
  assign pc_nxt = $signed({1'b0, gain}) * vel;

  always_ff @(posedge clk) begin
    if (en_a) begin
      pk_r  <= pk_nxt;
      pc_r  <= pc_nxt;
      act_r <= active;
    end
  end

  assign sum = -SUM_W'(pk_r) - SUM_W'(pc_r);

  always_comb begin
    if (sum > LIMIT) begin
      sat = LIMIT;
    end else if (sum < -LIMIT) begin
      sat = -LIMIT;
    end else begin
      sat = sum;
    end
    force_nxt = act_r ? sat[FORCE_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      force_r <= force_nxt;
    end
  end

  assign force_o = force_r;

endmodule

FILE: design/ssdc_ctrl.sv
// ----------------------------------------------------------------------------
// ssdc_ctrl: registers, tick and recenter counters
// Decodes gain stage and driven axes per tick and runs the recenter delay.
// ----------------------------------------------------------------------------
module ssdc_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  ssdc_pkg::reg_idx_t                 cfg_idx,
  input  logic [ssdc_pkg::CFG_W-1:0]         cfg_val,
  input  logic                               step,
  input  logic                               button,
  output ssdc_pkg::ctl_t                     ctl,
  output logic signed [ssdc_pkg::POS_W-1:0]  center_x,
  output logic signed [ssdc_pkg::POS_W-1:0]  center_y,
  output logic signed [ssdc_pkg::POS_W-1:0]  center_z,
  output logic [ssdc_pkg::GAIN_W-1:0]        gain
);
  import ssdc_pkg::*;

  logic [1:0]            mode_r;
  logic signed [POS_W-1:0] cx_r, cy_r, cz_r;
  logic [GAIN_W-1:0]     gain_r;
  logic [TICK_W-1:0]     s1_r, s2_r, rdly_r;

  logic [CNT_W-1:0]      tick_r, tick_nxt;
  logic [CNT_W-1:0]      dly_r, dly_nxt, dly_inc;
  logic                  pend_r, pend_nxt;
  logic                  busy, restart, centering;
  logic [2:0]            mode_act;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0;
      cx_r   <= '0;
      cy_r   <= '0;
      cz_r   <= POS_W'(50000);
      gain_r <= GAIN_W'(5);
      s1_r   <= TICK_W'(1000);
      s2_r   <= TICK_W'(1500);
      rdly_r <= TICK_W'(1000);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_AXIS_MODE: mode_r <= cfg_val[1:0];
        REG_CENTER_X:  cx_r   <= cfg_val;
        REG_CENTER_Y:  cy_r   <= cfg_val;
        REG_CENTER_Z:  cz_r   <= cfg_val;
        REG_DAMPING:   gain_r <= cfg_val[GAIN_W-1:0];
        REG_STAGE_ONE: s1_r   <= cfg_val[TICK_W-1:0];
        REG_STAGE_TWO: s2_r   <= cfg_val[TICK_W-1:0];
        REG_RECENTER:  rdly_r <= cfg_val[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  assign centering = tick_r < {1'b0, s2_r};
  assign mode_act  = {mode_r == 2'd3, mode_r >= 2'd2, mode_r != 2'd0};

  // restart loads tick directly with 1, the value after a park at 0 and one increment
  assign busy    = button || pend_r;
  assign dly_inc = dly_r + 1'b1;
  assign restart = busy && (dly_inc == {1'b0, rdly_r});

  always_comb begin
    pend_nxt = busy && !restart;
    dly_nxt  = dly_r;
    if (busy) begin
      dly_nxt = restart ? '0 : dly_inc;
    end
    if (restart) begin
      tick_nxt = CNT_W'(1);
    end else if (tick_r != '1) begin
      tick_nxt = tick_r + 1'b1;
    end else begin
      tick_nxt = tick_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
      dly_r  <= '0;
      pend_r <= 1'b0;
    end else if (step) begin
      tick_r <= tick_nxt;
      dly_r  <= dly_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_comb begin
    if (tick_r > {1'b0, s2_r}) begin
      ctl.stage = STAGE_TOP;
    end else if (tick_r > {1'b0, s1_r}) begin
      ctl.stage = STAGE_MID;
    end else begin
      ctl.stage = STAGE_INIT;
    end
    ctl.active  = centering ? 3'b111 : mode_act;
    ctl.pending = pend_nxt;
  end

  assign center_x = cx_r;
  assign center_y = cy_r;
  assign center_z = cz_r;
  assign gain     = gain_r;

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the staged spring-damper centering block
// Streams control ticks through the block under bursty input and stalled
// output. A cycle-free model of the controller predicts each result word,
// and the checker compares it field by field. The register setup changes
// between test phases, while the block is drained.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ssdc_pkg::*;

  typedef struct {
    logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
    logic signed [VEL_W-1:0] vel_x, vel_y, vel_z;
    logic                    button;
  } tick_in_t;

  typedef struct {
    logic [FORCE_W-1:0] force_x, force_y, force_z;
    logic               pending;
    stage_t             stage;
  } force_word_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [95:0]  out_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_index;
  logic [17:0]  cfg_data;

  staged_spring_damper_centering DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // register mirror
  logic [1:0]              reg_axis_mode;
  logic signed [CFG_W-1:0] reg_center_x, reg_center_y, reg_center_z;
  logic [GAIN_W-1:0]       reg_damping;
  logic [TICK_W-1:0]       reg_stage_one, reg_stage_two, reg_recenter;

  // controller state mirror
  logic [CNT_W-1:0] tick_cnt;
  logic [CNT_W-1:0] delay_cnt;
  logic             recenter_busy;

  force_word_t force_queue[$];

  int errors;
  int words_checked;
  int restarts;
  int held_ticks;
  int stage_seen[3];

  // traffic shaping
  int burst_max;
  int gap_max;
  int burst_left;
  int stall_mode;
  int rx_cycle;

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic logic [FORCE_W-1:0] spring_force(longint k, longint p, longint c,
                                                      longint v);
    longint f;
    f = -k * (p - c) - longint'(reg_damping) * v;
    if (f > 64'sd1000000000) f = 64'sd1000000000;
    if (f < -64'sd1000000000) f = -64'sd1000000000;
    return f[FORCE_W-1:0];
  endfunction

  function automatic force_word_t advance_controller(tick_in_t t);
    force_word_t r;
    longint      kx, ky, kz;
    logic [1:0]  active;
    if (tick_cnt > {1'b0, reg_stage_two}) begin
      r.stage = STAGE_TOP;
      kx = longint'(K_TOP);
      ky = kx;
      kz = kx;
    end else if (tick_cnt > {1'b0, reg_stage_one}) begin
      r.stage = STAGE_MID;
      kx = longint'(K_MID);
      ky = kx;
      kz = kx;
    end else begin
      r.stage = STAGE_INIT;
      kx = longint'(K_SOFT_XY);
      ky = kx;
      kz = longint'(K_SOFT_Z);
    end
    // all axes driven while centering
    active = (tick_cnt < {1'b0, reg_stage_two}) ? 2'd3 : reg_axis_mode;
    r.force_x = (active >= 2'd1) ? spring_force(kx, t.pos_x, reg_center_x, t.vel_x) : '0;
    r.force_y = (active >= 2'd2) ? spring_force(ky, t.pos_y, reg_center_y, t.vel_y) : '0;
    r.force_z = (active >= 2'd3) ? spring_force(kz, t.pos_z, reg_center_z, t.vel_z) : '0;
    if (t.button || recenter_busy) begin
      recenter_busy = 1'b1;
      delay_cnt = delay_cnt + 1'b1;
      if (delay_cnt == {1'b0, reg_recenter}) begin
        tick_cnt = '0;
        delay_cnt = '0;
        recenter_busy = 1'b0;
        restarts++;
      end
    end
    if (tick_cnt != '1) tick_cnt = tick_cnt + 1'b1;
    else held_ticks++;
    r.pending = recenter_busy;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic tick_in_t make_tick(int px, int py, int pz, int vx, int vy, int vz,
                                         bit btn);
    tick_in_t t;
    t.pos_x = POS_W'(px);
    t.pos_y = POS_W'(py);
    t.pos_z = POS_W'(pz);
    t.vel_x = VEL_W'(vx);
    t.vel_y = VEL_W'(vy);
    t.vel_z = VEL_W'(vz);
    t.button = btn;
    return t;
  endfunction

  function automatic int pick_pos();
    case ($urandom_range(0, 9))
      0:       return -100000;
      1:       return 100000;
      2:       return int'($urandom_range(0, 200)) - 100;
      3:       return int'($urandom);   // any 18-bit pattern
      default: return int'($urandom_range(0, 200000)) - 100000;
    endcase
  endfunction

  function automatic int pick_vel();
    case ($urandom_range(0, 9))
      0:       return -4000000;
      1:       return 4000000;
      2:       return int'($urandom_range(0, 2000)) - 1000;
      3:       return int'($urandom);   // any 23-bit pattern
      default: return int'($urandom_range(0, 8000000)) - 4000000;
    endcase
  endfunction

  function automatic tick_in_t random_tick(int unsigned btn_permille);
    return make_tick(pick_pos(), pick_pos(), pick_pos(), pick_vel(), pick_vel(), pick_vel(),
                     $urandom_range(0, 999) < btn_permille);
  endfunction

  function automatic int random_center();
    case ($urandom_range(0, 5))
      0:       return -100000;
      1:       return 100000;
      2:       return int'($urandom);
      default: return int'($urandom_range(0, 200000)) - 100000;
    endcase
  endfunction

  // junk in the unused upper bits of a narrow register now and then
  function automatic int stray_bits(int value, int width);
    if ($urandom_range(0, 3) != 0) return value;
    return int'($urandom_range(0, (1 << (CFG_W - width)) - 1) << width) | value;
  endfunction

  task automatic send_word(tick_in_t t);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, t.button, t.vel_z, t.vel_y, t.vel_x, t.pos_z, t.pos_y, t.pos_x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    force_queue.push_back(advance_controller(t));
  endtask

  task automatic idle_gap(int cycles);
    @(negedge clk);
    in_tvalid <= 1'b0;
    repeat (cycles - 1) @(posedge clk);
  endtask

  task automatic run_items(int count, int unsigned btn_permille);
    for (int i = 0; i < count; i++) begin
      if (gap_max > 0 && burst_left <= 0) begin
        idle_gap($urandom_range(1, gap_max));
        burst_left = $urandom_range(1, burst_max);
      end
      send_word(random_tick(btn_permille));
      burst_left--;
    end
  endtask

  // let a running recenter delay run out so the next setup starts clean
  task automatic finish_recenter();
    while (recenter_busy) send_word(random_tick(0));
  endtask

  task automatic set_traffic(int bmax, int gmax, int smode);
    burst_max  = bmax;
    gap_max    = gmax;
    burst_left = $urandom_range(1, bmax);
    stall_mode = smode;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (force_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, int value);
    logic [CFG_W-1:0] v;
    v = value[CFG_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_AXIS_MODE: reg_axis_mode = v[1:0];
      REG_CENTER_X:  reg_center_x  = v;
      REG_CENTER_Y:  reg_center_y  = v;
      REG_CENTER_Z:  reg_center_z  = v;
      REG_DAMPING:   reg_damping   = v[GAIN_W-1:0];
      REG_STAGE_ONE: reg_stage_one = v[TICK_W-1:0];
      REG_STAGE_TWO: reg_stage_two = v[TICK_W-1:0];
      REG_RECENTER:  reg_recenter  = v[TICK_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------- tests
  // reset values: stage 0 gains, all axes driven, field extremes
  task automatic test_reset_defaults();
    send_word(make_tick(0, 0, 0, 0, 0, 0, 0));
    send_word(make_tick(100000, 100000, 100000, 0, 0, 0, 0));
    send_word(make_tick(-100000, -100000, -100000, -4000000, -4000000, -4000000, 0));
    send_word(make_tick(0, 0, 50000, 4000000, 4000000, 4000000, 0));
    send_word(make_tick(131071, 131071, 131071, -4194304, -4194304, -4194304, 0));
    send_word(make_tick(-131072, -131072, -131072, 4194303, 4194303, 4194303, 0));
    send_word(make_tick(-1, 1, 50000, -1, 1, 0, 0));
    send_word(make_tick(87381, -87382, 21845, 2796202, -2796203, 1398101, 0));
  endtask

  // short thresholds: restart, walk through all three stages, then one axis
  task automatic test_stage_walk();
    wait_idle();
    write_reg(REG_STAGE_ONE, 2);
    write_reg(REG_STAGE_TWO, 4);
    write_reg(REG_RECENTER, 1);
    write_reg(REG_AXIS_MODE, 1);
    write_reg(REG_CENTER_X, -131072);
    write_reg(REG_CENTER_Y, 131071);
    write_reg(REG_DAMPING, 15);
    send_word(make_tick(131071, -131072, 0, 4194303, -4194304, 0, 1));
    send_word(make_tick(131071, -131072, 100000, 4194303, -4194304, 4000000, 0));
    send_word(make_tick(-100000, 100000, -100000, -4000000, 4000000, -4000000, 0));
    send_word(make_tick(131071, -131072, 131071, 4194303, -4194304, 4194303, 0));
    send_word(make_tick(-131072, 131071, -131072, -4194304, 4194303, -4194304, 0));
    send_word(make_tick(131071, -131072, 131071, 4194303, -4194304, 4194303, 0));
    send_word(make_tick(1000, 1000, 1000, 1000, 1000, 1000, 0));
    // press during top stage, restart on the same tick
    send_word(make_tick(-131072, 131071, 5, -4194304, 4194303, 5, 1));
    send_word(make_tick(50, -50, 50, -50, 50, -50, 0));
  endtask

  // every axis mode after centering, extreme centers and damping
  task automatic test_axis_modes();
    int s1;
    for (int m = 0; m < 4; m++) begin
      wait_idle();
      s1 = $urandom_range(1, 15);
      write_reg(REG_AXIS_MODE, m);
      write_reg(REG_STAGE_ONE, s1);
      write_reg(REG_STAGE_TWO, s1 + $urandom_range(1, 15));
      write_reg(REG_RECENTER, $urandom_range(1, 30));
      write_reg(REG_DAMPING, (m % 2) ? 15 : 0);
      write_reg(REG_CENTER_X, (m % 2) ? 100000 : -100000);
      write_reg(REG_CENTER_Y, (m % 2) ? -100000 : 100000);
      write_reg(REG_CENTER_Z, random_center());
      set_traffic(1 + 10 * m, m, m);
      send_word(random_tick(1000));
      run_items(100, 20);
      finish_recenter();
    end
  endtask

  // stage one above stage two, and zero thresholds
  task automatic test_threshold_corners();
    wait_idle();
    write_reg(REG_AXIS_MODE, 3);
    write_reg(REG_STAGE_ONE, 20);
    write_reg(REG_STAGE_TWO, 5);
    write_reg(REG_RECENTER, 3);
    set_traffic(8, 3, 1);
    send_word(random_tick(1000));
    run_items(60, 30);
    finish_recenter();
    wait_idle();
    write_reg(REG_AXIS_MODE, 2);
    write_reg(REG_STAGE_ONE, 0);
    write_reg(REG_STAGE_TWO, 0);
    set_traffic(30, 0, 2);
    run_items(60, 30);
    finish_recenter();
    wait_idle();
    write_reg(REG_STAGE_TWO, 10);
    set_traffic(4, 5, 3);
    run_items(60, 30);
    finish_recenter();
  endtask

  task automatic test_random_setups();
    for (int p = 0; p < 8; p++) begin
      wait_idle();
      write_reg(REG_AXIS_MODE, stray_bits($urandom_range(0, 3), 2));
      write_reg(REG_CENTER_X, random_center());
      write_reg(REG_CENTER_Y, random_center());
      write_reg(REG_CENTER_Z, random_center());
      write_reg(REG_DAMPING, stray_bits($urandom_range(0, 15), GAIN_W));
      write_reg(REG_STAGE_ONE, stray_bits($urandom_range(0, 40), TICK_W));
      write_reg(REG_STAGE_TWO, stray_bits($urandom_range(0, 60), TICK_W));
      write_reg(REG_RECENTER, stray_bits($urandom_range(1, 40), TICK_W));
      set_traffic($urandom_range(1, 40), $urandom_range(0, 8), $urandom_range(0, 3));
      run_items(80, $urandom_range(0, 40));
      finish_recenter();
    end
  endtask

  // stage thresholds at the top of their range; a zero recenter delay keeps
  // the delay pending for the rest of the run
  task automatic test_counter_limits();
    wait_idle();
    write_reg(REG_AXIS_MODE, 2);
    write_reg(REG_STAGE_ONE, 32766);
    write_reg(REG_STAGE_TWO, 32767);
    write_reg(REG_RECENTER, 0);
    set_traffic(200, 2, 1);
    run_items(150, 0);
    send_word(random_tick(1000));
    run_items(100, 20);
  endtask

  // ---------------------------------------------------------------- checker
  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    if (errors <= 20)
      $display("tb_top: mismatch on %s, word %0d: got %0d, want %0d",
               what, words_checked, got, want);
  endtask

  always @(negedge clk) begin
    rx_cycle++;
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 3) != 0);
      2:       out_tready <= ((rx_cycle % 5) >= 2);
      default: out_tready <= ($urandom_range(0, 4) < 2);
    endcase
  end

  always @(posedge clk) begin : check_words
    force_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (force_queue.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        want = force_queue.pop_front();
        if (out_tdata[30:0] !== want.force_x)
          report_mismatch("force_x", $signed(out_tdata[30:0]), $signed(want.force_x));
        if (out_tdata[61:31] !== want.force_y)
          report_mismatch("force_y", $signed(out_tdata[61:31]), $signed(want.force_y));
        if (out_tdata[92:62] !== want.force_z)
          report_mismatch("force_z", $signed(out_tdata[92:62]), $signed(want.force_z));
        if (out_tdata[93] !== want.pending)
          report_mismatch("recenter_pending", out_tdata[93], want.pending);
        if (out_tdata[95:94] !== want.stage)
          report_mismatch("gain_stage", out_tdata[95:94], want.stage);
        stage_seen[want.stage]++;
      end
      words_checked++;
    end
  end

  // ---------------------------------------------------------------- main
  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_AXIS_MODE;
    cfg_data   = '0;
    errors = 0;
    words_checked = 0;
    restarts = 0;
    held_ticks = 0;
    stage_seen = '{0, 0, 0};
    reg_axis_mode = 2'd0;
    reg_center_x  = '0;
    reg_center_y  = '0;
    reg_center_z  = 18'sd50000;
    reg_damping   = 4'd5;
    reg_stage_one = 15'd1000;
    reg_stage_two = 15'd1500;
    reg_recenter  = 15'd1000;
    tick_cnt      = '0;
    delay_cnt     = '0;
    recenter_busy = 1'b0;
    set_traffic(1, 0, 0);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_reset_defaults();
    test_stage_walk();
    test_axis_modes();
    test_threshold_corners();
    test_random_setups();
    test_counter_limits();

    wait_idle();
    repeat (10) @(posedge clk);
    $display("tb_top: %0d words checked, %0d recenter restarts, %0d ticks at counter ceiling",
             words_checked, restarts, held_ticks);
    $display("tb_top: gain stages seen 0/1/2: %0d/%0d/%0d",
             stage_seen[0], stage_seen[1], stage_seen[2]);
    if (errors == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    #60_000_000;
    $display("tb_top: timeout");
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
